// File: rtl/opc_pkg.sv
// Shared types, constants and helpers of the oscillator phase coherence block.
`default_nettype none
package opc_pkg;

	localparam int PHASE_W = 16;
	localparam int TRIG_W  = 15;
	localparam int CNT_W   = 13;
	localparam int SUM_W   = 29;
	localparam int MAG_W   = 28;
	localparam int OUT_W   = 16;
	localparam int POLY_W  = 31;
	localparam int IDX_W   = 8;
	localparam int SQ_W    = 56;

	localparam logic [CNT_W-1:0]  MAX_OSC       = 13'd4096;
	localparam logic [CNT_W-1:0]  OSC_RESET     = 13'd1024;
	localparam logic [CNT_W-1:0]  MODULE_RESET  = 13'd32;
	localparam logic [POLY_W-1:0] POLY_A        = 31'd1686629713;
	localparam logic [POLY_W-1:0] POLY_B        = 31'd688904866;
	localparam logic [POLY_W-1:0] POLY_C        = 31'd76016977;
	localparam logic [POLY_W-1:0] ONE_Q30       = 31'h4000_0000;
	localparam logic [TRIG_W-1:0] TRIG_AMP      = 15'h7fff;
	localparam logic [OUT_W-1:0]  OUT_SAT       = 16'hffff;

	localparam logic [IDX_W-1:0] REG_OSC_COUNT   = 8'd0;
	localparam logic [IDX_W-1:0] REG_MODULE_SIZE = 8'd1;

	typedef struct packed {
		logic signed [SUM_W-1:0] mod_cos;
		logic signed [SUM_W-1:0] mod_sin;
		logic signed [SUM_W-1:0] glob_cos;
		logic signed [SUM_W-1:0] glob_sin;
		logic                    last;
		logic [CNT_W-1:0]        count;
	} opc_entry_t;

	typedef enum logic [1:0] {F_IDLE, F_CALC, F_ACC, F_PUSH} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE, B_SQ_C, B_SQ_S, B_ROOT, B_ACC, B_DIV_INIT, B_DIV, B_OUT
	} back_state_t;

	function automatic logic [CNT_W-1:0] effective(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 13'd1;
		end else if (v > MAX_OSC) begin
			r = MAX_OSC;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/opc_front.sv
// Front end: accepts phases, evaluates cosine and sine, keeps the vector sums.
`default_nettype none
module opc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [opc_pkg::PHASE_W-1:0] s_axis_tdata,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [opc_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [opc_pkg::CNT_W-1:0]   cfg_data,
	output logic                             push,
	output opc_pkg::opc_entry_t              entry,
	input  wire logic                        q_full
);

	opc_pkg::front_state_t state_q, state_d;
	logic [opc_pkg::CNT_W-1:0]  osc_count_q, module_size_q;
	logic [1:0]                 quad_q;
	logic [opc_pkg::POLY_W-1:0] x_q, x2_q, t_q;
	logic [opc_pkg::TRIG_W-1:0] sx_q, sy_q;
	logic [2:0]                 step_q;
	logic [opc_pkg::CNT_W-1:0]  idx_q, pos_q;
	logic signed [opc_pkg::SUM_W-1:0] gc_q, gs_q, mc_q, ms_q;
	opc_pkg::opc_entry_t entry_q;

	logic [opc_pkg::POLY_W-1:0] v, mul_a, mul_b, psh;
	logic [2*opc_pkg::POLY_W-1:0] prod;
	logic [31:0]                rnd_sum, rnd;
	logic [opc_pkg::TRIG_W-1:0] trig;
	logic signed [opc_pkg::TRIG_W:0] cv, sv;
	logic signed [opc_pkg::SUM_W-1:0] gc_n, gs_n, mc_n, ms_n;
	logic [opc_pkg::CNT_W-1:0]  n_eff, m_eff;
	logic                       end_frame, end_mod;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == opc_pkg::F_IDLE);
	assign push = (state_q == opc_pkg::F_PUSH) && !q_full;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_count_q   <= opc_pkg::OSC_RESET;
			module_size_q <= opc_pkg::MODULE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == opc_pkg::REG_OSC_COUNT) begin
				osc_count_q <= cfg_data;
			end else if (cfg_index == opc_pkg::REG_MODULE_SIZE) begin
				module_size_q <= cfg_data;
			end
		end
	end

	// One shared multiplier walks the polynomial: x*x, C term, B term, final x*t.
	always_comb begin
		v = step_q[2] ? (opc_pkg::ONE_Q30 - x_q) : x_q;
		case (step_q[1:0])
			2'd0: begin mul_a = v;    mul_b = v; end
			2'd1: begin mul_a = x2_q; mul_b = opc_pkg::POLY_C; end
			2'd2: begin mul_a = x2_q; mul_b = t_q; end
			default: begin mul_a = v; mul_b = t_q; end
		endcase
		prod    = mul_a * mul_b;
		psh     = prod[60:30];
		rnd_sum = {1'b0, psh} + (32'd1 << (29 - opc_pkg::TRIG_W));
		rnd     = rnd_sum >> (30 - opc_pkg::TRIG_W);
		trig    = (rnd > 32'(opc_pkg::TRIG_AMP)) ? opc_pkg::TRIG_AMP :
			rnd[opc_pkg::TRIG_W-1:0];
	end

	always_comb begin
		case (quad_q)
			2'd0: begin sv = $signed({1'b0, sx_q}); cv = $signed({1'b0, sy_q}); end
			2'd1: begin sv = $signed({1'b0, sy_q}); cv = -$signed({1'b0, sx_q}); end
			2'd2: begin sv = -$signed({1'b0, sx_q}); cv = -$signed({1'b0, sy_q}); end
			default: begin sv = -$signed({1'b0, sy_q}); cv = $signed({1'b0, sx_q}); end
		endcase
		gc_n = gc_q + opc_pkg::SUM_W'(cv);
		gs_n = gs_q + opc_pkg::SUM_W'(sv);
		mc_n = mc_q + opc_pkg::SUM_W'(cv);
		ms_n = ms_q + opc_pkg::SUM_W'(sv);
		n_eff = opc_pkg::effective(osc_count_q);
		m_eff = opc_pkg::effective(module_size_q);
		end_frame = ({1'b0, idx_q} + 14'd1) >= {1'b0, n_eff};
		end_mod   = end_frame || (({1'b0, pos_q} + 14'd1) >= {1'b0, m_eff});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			opc_pkg::F_IDLE: if (s_axis_tvalid) state_d = opc_pkg::F_CALC;
			opc_pkg::F_CALC: if (step_q == 3'd7) state_d = opc_pkg::F_ACC;
			opc_pkg::F_ACC:  state_d = end_mod ? opc_pkg::F_PUSH : opc_pkg::F_IDLE;
			opc_pkg::F_PUSH: if (!q_full) state_d = opc_pkg::F_IDLE;
			default:         state_d = opc_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opc_pkg::F_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
			pos_q   <= '0;
			gc_q    <= '0;
			gs_q    <= '0;
			mc_q    <= '0;
			ms_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				opc_pkg::F_IDLE: begin
					step_q <= '0;
				end
				opc_pkg::F_CALC: begin
					step_q <= step_q + 3'd1;
				end
				opc_pkg::F_ACC: begin
					if (end_frame) begin
						idx_q <= '0;
						pos_q <= '0;
						gc_q  <= '0;
						gs_q  <= '0;
						mc_q  <= '0;
						ms_q  <= '0;
					end else begin
						idx_q <= idx_q + 13'd1;
						gc_q  <= gc_n;
						gs_q  <= gs_n;
						if (end_mod) begin
							pos_q <= '0;
							mc_q  <= '0;
							ms_q  <= '0;
						end else begin
							pos_q <= pos_q + 13'd1;
							mc_q  <= mc_n;
							ms_q  <= ms_n;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == opc_pkg::F_IDLE && s_axis_tvalid) begin
			quad_q <= s_axis_tdata[opc_pkg::PHASE_W-1 -: 2];
			x_q    <= {1'b0, s_axis_tdata[opc_pkg::PHASE_W-3:0],
				{(32 - opc_pkg::PHASE_W){1'b0}}};
		end
		if (state_q == opc_pkg::F_CALC) begin
			case (step_q[1:0])
				2'd0: x2_q <= psh;
				2'd1: t_q  <= opc_pkg::POLY_B - psh;
				2'd2: t_q  <= opc_pkg::POLY_A - psh;
				default: begin
					if (step_q[2]) sy_q <= trig;
					else sx_q <= trig;
				end
			endcase
		end
		if (state_q == opc_pkg::F_ACC) begin
			entry_q.mod_cos  <= mc_n;
			entry_q.mod_sin  <= ms_n;
			entry_q.glob_cos <= gc_n;
			entry_q.glob_sin <= gs_n;
			entry_q.last     <= end_frame;
			entry_q.count    <= n_eff;
		end
	end

endmodule
`default_nettype wire

// File: rtl/opc_queue.sv
// Two-entry queue of closed modules between front and back end.
`default_nettype none
module opc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire opc_pkg::opc_entry_t push_entry,
	output logic                     full,
	input  wire logic                pop,
	output logic                     not_empty,
	output opc_pkg::opc_entry_t      head
);

	opc_pkg::opc_entry_t slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head      = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_entry;
	end

endmodule
`default_nettype wire

// File: rtl/opc_back.sv
// Back end: module magnitudes, total, and the two Q0.16 divisions.
`default_nettype none
module opc_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire opc_pkg::opc_entry_t        q_head,
	output logic                            pop,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	output logic [2*opc_pkg::OUT_W-1:0]     m_axis_tdata
);

	opc_pkg::back_state_t state_q, state_d;
	logic signed [opc_pkg::SUM_W-1:0] c_q, s_q, gc_q, gs_q;
	logic                       last_q, glob_q, sel_q;
	logic [opc_pkg::CNT_W-1:0]  n_q;
	logic [opc_pkg::SQ_W-1:0]   sq_q, v_q, res_q, bit_q;
	logic [opc_pkg::MAG_W-1:0]  total_q, num_q, rem_q, den_q;
	logic [opc_pkg::OUT_W-1:0]  quo_q, gout_q, mout_q;
	logic [4:0]                 cnt_q;

	logic [opc_pkg::SUM_W-1:0]  abs_v;
	logic [opc_pkg::MAG_W-1:0]  abs_n;
	logic [opc_pkg::SQ_W-1:0]   sq_n, trial;
	logic [opc_pkg::MAG_W:0]    rem2;
	logic [opc_pkg::MAG_W-1:0]  den_n;

	assign pop           = (state_q == opc_pkg::B_IDLE) && q_valid;
	assign m_axis_tvalid = (state_q == opc_pkg::B_OUT);
	assign m_axis_tdata  = {mout_q, gout_q};

	always_comb begin
		abs_v = (state_q == opc_pkg::B_SQ_C) ? c_q : s_q;
		if (abs_v[opc_pkg::SUM_W-1]) abs_v = -abs_v;
		abs_n = abs_v[opc_pkg::MAG_W-1:0];
		sq_n  = abs_n * abs_n;
		trial = res_q + bit_q;
		rem2  = {rem_q, 1'b0};
		den_n = opc_pkg::MAG_W'(n_q) * opc_pkg::MAG_W'(opc_pkg::TRIG_AMP);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			opc_pkg::B_IDLE:     if (q_valid) state_d = opc_pkg::B_SQ_C;
			opc_pkg::B_SQ_C:     state_d = opc_pkg::B_SQ_S;
			opc_pkg::B_SQ_S:     state_d = opc_pkg::B_ROOT;
			opc_pkg::B_ROOT:     if (bit_q == '0) state_d = opc_pkg::B_ACC;
			opc_pkg::B_ACC: begin
				if (glob_q) state_d = opc_pkg::B_DIV_INIT;
				else if (last_q) state_d = opc_pkg::B_SQ_C;
				else state_d = opc_pkg::B_IDLE;
			end
			opc_pkg::B_DIV_INIT: state_d = (num_q >= den_n) ?
				(sel_q ? opc_pkg::B_OUT : opc_pkg::B_DIV_INIT) : opc_pkg::B_DIV;
			opc_pkg::B_DIV: begin
				if (cnt_q == 5'd1) state_d = sel_q ? opc_pkg::B_OUT : opc_pkg::B_DIV_INIT;
			end
			opc_pkg::B_OUT:      if (m_axis_tready) state_d = opc_pkg::B_IDLE;
			default:             state_d = opc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opc_pkg::B_IDLE;
			total_q <= '0;
			glob_q  <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				opc_pkg::B_IDLE: begin
					glob_q <= 1'b0;
					sel_q  <= 1'b0;
				end
				opc_pkg::B_ACC: begin
					if (!glob_q) begin
						total_q <= total_q + res_q[opc_pkg::MAG_W-1:0];
						glob_q  <= last_q;
					end
				end
				opc_pkg::B_DIV_INIT: begin
					if (num_q >= den_n) sel_q <= 1'b1;
				end
				opc_pkg::B_DIV: begin
					if (cnt_q == 5'd1) sel_q <= 1'b1;
				end
				opc_pkg::B_OUT: begin
					if (m_axis_tready) total_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			opc_pkg::B_IDLE: begin
				c_q    <= q_head.mod_cos;
				s_q    <= q_head.mod_sin;
				gc_q   <= q_head.glob_cos;
				gs_q   <= q_head.glob_sin;
				last_q <= q_head.last;
				n_q    <= q_head.count;
			end
			opc_pkg::B_SQ_C: sq_q <= sq_n;
			opc_pkg::B_SQ_S: begin
				v_q   <= sq_q + sq_n;
				res_q <= '0;
				bit_q <= opc_pkg::SQ_W'(1) << (opc_pkg::SQ_W - 2);
			end
			opc_pkg::B_ROOT: begin
				if (bit_q != '0) begin
					if (v_q >= trial) begin
						v_q   <= v_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			opc_pkg::B_ACC: begin
				c_q   <= gc_q;
				s_q   <= gs_q;
				num_q <= res_q[opc_pkg::MAG_W-1:0];
			end
			opc_pkg::B_DIV_INIT: begin
				den_q <= den_n;
				rem_q <= num_q;
				quo_q <= '0;
				cnt_q <= 5'd16;
				if (num_q >= den_n) begin
					if (sel_q) mout_q <= opc_pkg::OUT_SAT;
					else begin
						gout_q <= opc_pkg::OUT_SAT;
						num_q  <= total_q;
					end
				end
			end
			opc_pkg::B_DIV: begin
				cnt_q <= cnt_q - 5'd1;
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= opc_pkg::MAG_W'(rem2 - {1'b0, den_q});
					quo_q <= {quo_q[opc_pkg::OUT_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2[opc_pkg::MAG_W-1:0];
					quo_q <= {quo_q[opc_pkg::OUT_W-2:0], 1'b0};
				end
				if (cnt_q == 5'd1) begin
					if (sel_q) begin
						mout_q <= {quo_q[opc_pkg::OUT_W-2:0], rem2 >= {1'b0, den_q}};
					end else begin
						gout_q <= {quo_q[opc_pkg::OUT_W-2:0], rem2 >= {1'b0, den_q}};
						num_q  <= total_q;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/oscillator_phase_coherence.sv
// Top level of the oscillator phase coherence block: front end, queue, back end.
//
//  channel   dir   handshake             payload
//  s_axis    in    tvalid / tready       tdata[15:0] phase
//  m_axis    out   tvalid / tready       tdata[15:0] global_order, [31:16] modular_order
//  cfg       in    cfg_valid / cfg_ready cfg_index, cfg_data (0 oscillator_count, 1 module_size)
//
// Each phase passes through the front end in eight steps of the one shared
// polynomial multiplier, one accumulate and one return to idle, plus a push when a module closes.
// The back end takes each closed module through two squaring steps, the one-bit-a-cycle
// square root and an accumulate; a frame end adds a second root, two divisions (skipped
// when the result saturates) and the result state, which waits for m_axis_tready.
// Reset clears the front-end counters and sums, the running total and the queue; no clearing pass is needed.
// A stalled result holds in the back end while the front end keeps taking phases
// until the two-entry queue fills.
`default_nettype none
module oscillator_phase_coherence (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [opc_pkg::PHASE_W-1:0]   s_axis_tdata,   // [15:0] phase
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [2*opc_pkg::OUT_W-1:0]        m_axis_tdata,   // [15:0] global_order, [31:16] modular_order
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [opc_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [opc_pkg::CNT_W-1:0]     cfg_data
);

	logic                push, q_full, q_valid, pop;
	opc_pkg::opc_entry_t push_entry, q_head;

	// Front: evaluate cosine and sine of each phase, close modules and frames.
	opc_front u_front (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.push, .entry(push_entry), .q_full
	);

	// Queue: decouple the slow root and division work from phase intake.
	opc_queue u_queue (
		.clk, .arst_n,
		.push, .push_entry, .full(q_full),
		.pop, .not_empty(q_valid), .head(q_head)
	);

	// Back: magnitudes, running total, final results.
	opc_back u_back (
		.clk, .arst_n,
		.q_valid, .q_head, .pop,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("front end took a second phase while busy");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
		else $error("result repeated");
`endif

endmodule
`default_nettype wire
